### sv/tlvd_pkg.sv
// ----------------------------------------------------------------------------
// tlvd_pkg
// Shared types and codes for the TLV stream deframer.
// ----------------------------------------------------------------------------
package tlvd_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned HCOUNT_W  = 3;
   localparam int unsigned RSP_DATA_W = 80;

   // header byte positions: 0..3 tag, 4..7 length
   localparam logic [HCOUNT_W-1:0] HDR_FIRST_LEN = 3'd4;
   localparam logic [HCOUNT_W-1:0] HDR_LAST      = 3'd7;
   localparam logic [HCOUNT_W-1:0] HDR_START     = 3'd0;

   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_VALUE  = 1'b1;

   localparam logic [1:0] END_NONE      = 2'd0;
   localparam logic [1:0] END_OK        = 2'd1;
   localparam logic [1:0] END_TRUNC_HDR = 2'd2;
   localparam logic [1:0] END_VALUE_RUN = 2'd3;

   typedef struct packed {
      logic                byte_kind;
      logic [WORD_W-1:0]   current_tag;
      logic [WORD_W-1:0]   current_length;
      logic [BYTE_W-1:0]   value_data;
      logic                header_done;
      logic                record_done;
      logic [1:0]          end_status;
   } result_type;

endpackage

### sv/tlv_stream_deframer.sv
// ----------------------------------------------------------------------------
// tlv_stream_deframer
// Splits a byte stream into tag/length/value records.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (req_*): one buffer byte per transaction in req_tdata,
//   req_tlast high on the final byte of the buffer. Each record in the
//   buffer is a 4-byte big-endian tag, a 4-byte big-endian length and that
//   many value bytes.
//   Result channel (rsp_*): exactly one transaction per input byte, in
//   order. rsp_tuser gives the byte kind (header or value), rsp_tlast marks
//   the byte that completes a record (also the last header byte of a
//   zero-length record). rsp_tdata carries tag, length, the byte itself, the
//   header-done flag and the end status, which is nonzero only on the final
//   byte of a buffer (ok, truncated header, value running past the end).
//   The result is registered, shown the cycle after its byte is taken; one
//   byte is taken every cycle, limited only by the single result register.
//   While the receiver stalls with a result pending, req_tready drops and
//   the pending result holds; the block resumes the cycle it is taken.
//   Reset empties the result register and clears all parse state; after the
//   final byte of a buffer the parse state clears the same way, so the next
//   byte starts a new buffer.
// ----------------------------------------------------------------------------
module tlv_stream_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [31:0] current_tag, [63:32] current_length,
                                    // [71:64] value_data, [72] header_done,
                                    // [74:73] end_status, [79:75] zero
   output logic        rsp_tuser,   // byte_kind
   output logic        rsp_tlast    // record_done
);
   import tlvd_pkg::*;

   result_type parse_result;
   result_type held_result;
   logic       accept;

   // advance parse state only on an accepted byte
   assign accept = req_tvalid && req_tready;

   tlvd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .result    (parse_result)
   );

   tlvd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (req_tvalid),
      .load_ready (req_tready),
      .load_data  (parse_result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (held_result)
   );

   // pack result fields, highest field first (tag in the lowest bits)
   assign rsp_tdata = {5'b0,
                       held_result.end_status,
                       held_result.header_done,
                       held_result.value_data,
                       held_result.current_length,
                       held_result.current_tag};
   assign rsp_tuser = held_result.byte_kind;
   assign rsp_tlast = held_result.record_done;

endmodule

### sv/tlvd_parse.sv
// ----------------------------------------------------------------------------
// tlvd_parse
// Parser state (header count, tag/length shifters, value countdown) and the
// per-byte result logic.
// ----------------------------------------------------------------------------
module tlvd_parse (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [7:0]                data_byte,
   input  logic                      last_byte,
   output tlvd_pkg::result_type      result
);
   import tlvd_pkg::*;

   logic [HCOUNT_W-1:0] hcount_ff, hcount_in;
   logic [WORD_W-1:0]   tag_ff, tag_in;
   logic [WORD_W-1:0]   len_ff, len_in;
   logic [WORD_W-1:0]   left_ff, left_in;
   logic                in_value_ff, in_value_in;

   logic [HCOUNT_W-1:0] hcount_nx;
   logic [WORD_W-1:0]   tag_nx, len_nx, left_nx;
   logic                in_value_nx;

   always_comb begin
      hcount_nx   = hcount_ff;
      tag_nx      = tag_ff;
      len_nx      = len_ff;
      left_nx     = left_ff;
      in_value_nx = in_value_ff;
      result      = '0;
      result.value_data = data_byte;

      if (in_value_ff) begin
         result.byte_kind = KIND_VALUE;
         left_nx = left_ff - WORD_W'(1);
         if (left_ff == WORD_W'(1)) begin
            in_value_nx        = 1'b0;
            result.record_done = 1'b1;
         end
      end else begin
         result.byte_kind = KIND_HEADER;
         if (hcount_ff < HDR_FIRST_LEN) begin
            tag_nx = {tag_ff[WORD_W-BYTE_W-1:0], data_byte};
         end else begin
            len_nx = {len_ff[WORD_W-BYTE_W-1:0], data_byte};
         end
         if (hcount_ff == HDR_LAST) begin
            hcount_nx          = HDR_START;
            result.header_done = 1'b1;
            if (len_nx == '0) begin
               result.record_done = 1'b1;
            end else begin
               in_value_nx = 1'b1;
               left_nx     = len_nx;
            end
         end else begin
            hcount_nx = hcount_ff + HCOUNT_W'(1);
         end
      end

      result.current_tag    = tag_nx;
      result.current_length = len_nx;

      // final byte: report and drop all state
      hcount_in   = hcount_nx;
      tag_in      = tag_nx;
      len_in      = len_nx;
      left_in     = left_nx;
      in_value_in = in_value_nx;
      if (last_byte) begin
         if (in_value_nx) begin
            result.end_status = END_VALUE_RUN;
         end else if (hcount_nx != HDR_START) begin
            result.end_status = END_TRUNC_HDR;
         end else begin
            result.end_status = END_OK;
         end
         hcount_in   = HDR_START;
         tag_in      = '0;
         len_in      = '0;
         left_in     = '0;
         in_value_in = 1'b0;
      end else begin
         result.end_status = END_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hcount_ff   <= HDR_START;
         tag_ff      <= '0;
         len_ff      <= '0;
         left_ff     <= '0;
         in_value_ff <= 1'b0;
      end else if (accept) begin
         hcount_ff   <= hcount_in;
         tag_ff      <= tag_in;
         len_ff      <= len_in;
         left_ff     <= left_in;
         in_value_ff <= in_value_in;
      end
   end

endmodule

### sv/tlvd_out_reg.sv
// ----------------------------------------------------------------------------
// tlvd_out_reg
// Result register with valid flag; loads whenever it is empty or drained.
// ----------------------------------------------------------------------------
module tlvd_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   output logic                  load_ready,
   input  tlvd_pkg::result_type  load_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tlvd_pkg::result_type  out_data
);
   import tlvd_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   assign load_ready = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_data   = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_ready) begin
         valid_ff <= load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ready && load_valid) begin
         data_ff <= load_data;
      end
   end

endmodule

### sv/tlvd_checker.sv
// ----------------------------------------------------------------------------
// tlvd_checker
// Port-level assertions for the TLV stream deframer.
// ----------------------------------------------------------------------------
module tlvd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);
   import tlvd_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // every accepted byte shows up next cycle with its byte passed through
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid
         && rsp_tdata[71:64] == $past(req_tdata))
      else $error("accepted byte not presented next cycle");

   // a stall with no room blocks the input
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while result stalled");

   // header completion only on header bytes; end status only on final bytes
   a_hdr_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[72] |-> rsp_tuser == KIND_HEADER)
      else $error("header done on a value byte");

   a_end_status: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> ((rsp_tdata[74:73] != END_NONE) == $past(req_tlast)))
      else $error("end status does not match final byte");

endmodule

bind tlv_stream_deframer tlvd_checker u_tlvd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
